FILE: sv/idr_pkg.sv
// Shared types, constants and helpers of the DPCM residual block.
package idr_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = 12;
    localparam int HGT_W      = 16;
    localparam int CNT_W      = (COL_W + 1 > WID_W) ? COL_W + 1 : WID_W;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int RES_W      = 14;
    localparam int DISP_W     = 8;
    localparam int FRAC_W     = 12;
    localparam int PROD_W     = COEF_W + PIX_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int K_W        = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MQ_DEPTH   = 4;
    localparam int MQ_PTR_W   = $clog2(MQ_DEPTH);
    localparam int MQ_CNT_W   = $clog2(MQ_DEPTH + 1);
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;

    localparam logic signed [COEF_W-1:0] COEF_A_RESET = 16'sd4096;
    localparam logic [WID_W-1:0]         WIDTH_RESET  = 12'd640;
    localparam logic [HGT_W-1:0]         HEIGHT_RESET = 16'd480;

    typedef enum logic [1:0] {
        MODE_LEFT    = 2'd0,
        MODE_UP      = 2'd1,
        MODE_LEFT_UP = 2'd2,
        MODE_PLANE   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic [WID_W-1:0]         width;
        logic [HGT_W-1:0]         height;
    } t_cfg;

    // One classified pixel with its neighbourhood, handed from front to back.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] upleft;
        t_mode            mode;
        logic             edge_pix;
        logic             frame_end;
    } t_desc;

    typedef struct packed {
        logic signed [RES_W-1:0] residual;
        logic [DISP_W-1:0]       display_code;
        logic                    edge_pixel;
        logic                    frame_end;
    } t_result;

    // Display offset for each predictor mode.
    function automatic logic [K_W-1:0] k_of_mode(input t_mode mode);
        logic [K_W-1:0] k;
        unique case (mode)
            MODE_LEFT:    k = 9'd128;
            MODE_UP:      k = 9'd128;
            MODE_LEFT_UP: k = 9'd256;
            MODE_PLANE:   k = 9'd384;
        endcase
        return k;
    endfunction

endpackage

FILE: sv/image_dpcm_residual_unit.sv
// Top level of the DPCM residual block: configuration registers and front/back wiring.
//
// Pixels enter in raster order through a queue-style port: one is taken at a clock
// edge where push is high and full is low. Results leave the same way: while empty
// is low the oldest result sits on the o_ ports and is taken when pop is high.
// Every pixel gives exactly one result, in order.
// Configuration is a separate valid/ready write port (ready is always high); write
// only while no pixel is in flight.
// After the edge that takes its pixel, a result passes the queue hand-over, product
// stage, sum stage and result queue write before it becomes visible.
// Throughput: one pixel per cycle while full is low, set by the row buffer read and
// write done together at the acceptance edge, and the pipelined multipliers behind it.
// When the receiver stops popping, the four-entry result queue fills, the back end
// stops draining the four-entry descriptor queue, and full rises once that fills.
// Reset is synchronous and active low: counters, neighbour registers and queues
// clear and the registers return to their defaults. The row buffer is not cleared;
// its first-row reads come before any write but never reach a result.
module image_dpcm_residual_unit
    import idr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [PIX_W-1:0]        i_pixel,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [RES_W-1:0] o_residual,
    output logic [DISP_W-1:0]       o_display_code,
    output logic                    o_edge_pixel,
    output logic                    o_frame_end,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg                r_cfg;
    logic                accept;
    logic                front_valid;
    t_desc               front_desc;
    t_desc               queue_desc;
    logic                queue_not_empty;
    logic [MQ_CNT_W-1:0] queue_count;
    logic                queue_pop;
    t_result             result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_LEFT;
            r_cfg.coef_a <= COEF_A_RESET;
            r_cfg.coef_b <= '0;
            r_cfg.coef_c <= '0;
            r_cfg.width  <= WIDTH_RESET;
            r_cfg.height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_cfg.mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_COEF_A: r_cfg.coef_a <= $signed(i_cfg_data);
                CFG_COEF_B: r_cfg.coef_b <= $signed(i_cfg_data);
                CFG_COEF_C: r_cfg.coef_c <= $signed(i_cfg_data);
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // The request in the front's f1 register still needs a queue slot.
    assign full   = ((MQ_CNT_W+1)'(queue_count) + (MQ_CNT_W+1)'(front_valid))
                    >= (MQ_CNT_W+1)'(MQ_DEPTH);
    assign accept = push && !full;

    idr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_pixel      (i_pixel),
        .o_desc_valid (front_valid),
        .o_desc       (front_desc)
    );

    idr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .i_desc      (front_desc),
        .i_pop       (queue_pop),
        .o_desc      (queue_desc),
        .o_not_empty (queue_not_empty),
        .o_count     (queue_count)
    );

    idr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_desc_valid (queue_not_empty),
        .i_desc       (queue_desc),
        .o_desc_pop   (queue_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (result)
    );

    assign o_residual     = result.residual;
    assign o_display_code = result.display_code;
    assign o_edge_pixel   = result.edge_pixel;
    assign o_frame_end    = result.frame_end;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_edge_residual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_edge_pixel) |-> (o_residual == '0))
        else $error("edge pixel with non-zero residual");

    a_edge_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_edge_pixel) |-> (o_display_code == 8'd64 ||
        o_display_code == 8'd128 || o_display_code == 8'd192))
        else $error("edge pixel with unexpected display code");
`endif

endmodule

FILE: sv/idr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module idr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and a write to the same address return the old word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/idr_front.sv
// Front end: raster counters, row buffer, neighbour registers and edge classification.
module idr_front
    import idr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_desc_valid,
    output t_desc            o_desc
);

    logic [COL_W-1:0] r_col;
    logic [HGT_W-1:0] r_row;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_upleft;
    logic             r_f1_valid;
    logic [PIX_W-1:0] r_f1_pixel;
    logic [PIX_W-1:0] r_f1_left;
    t_mode            r_f1_mode;
    logic             r_f1_edge;
    logic             r_f1_fend;

    logic [CNT_W-1:0] last_col_idx;
    logic [HGT_W-1:0] last_row_idx;
    logic             last_col;
    logic             last_row;
    logic             edge_pix;
    logic [COL_W-1:0] n_col;
    logic [HGT_W-1:0] n_row;
    logic [PIX_W-1:0] up_data;

    always_comb begin
        if (i_cfg.width == '0) begin
            last_col_idx = '0;
        end else if (CNT_W'(i_cfg.width) > CNT_W'(MAX_WIDTH)) begin
            last_col_idx = CNT_W'(MAX_WIDTH - 1);
        end else begin
            last_col_idx = CNT_W'(i_cfg.width) - CNT_W'(1);
        end
        last_row_idx = (i_cfg.height == '0) ? '0 : i_cfg.height - HGT_W'(1);
        last_col     = (CNT_W'(r_col) >= last_col_idx);
        last_row     = (r_row >= last_row_idx);

        unique case (i_cfg.mode)
            MODE_LEFT:    edge_pix = (r_col == '0);
            MODE_UP:      edge_pix = (r_row == '0);
            MODE_LEFT_UP: edge_pix = (r_col == '0) || (r_row == '0);
            MODE_PLANE:   edge_pix = (r_col == '0) || (r_row == '0);
        endcase

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + HGT_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    // The previous row's pixel at this column is read while the new one is written.
    idr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_accept),
        .i_waddr (r_col),
        .i_wdata (i_pixel),
        .i_re    (i_accept),
        .i_raddr (r_col),
        .o_rdata (up_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_upleft   <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= i_accept;
            if (i_accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= i_pixel;
            end
            if (r_f1_valid) begin
                r_upleft <= up_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_f1_pixel <= i_pixel;
            r_f1_left  <= r_left;
            r_f1_mode  <= i_cfg.mode;
            r_f1_edge  <= edge_pix;
            r_f1_fend  <= last_col && last_row;
        end
    end

    assign o_desc_valid = r_f1_valid;

    always_comb begin
        o_desc.pixel     = r_f1_pixel;
        o_desc.left      = r_f1_left;
        o_desc.up        = up_data;
        o_desc.upleft    = r_upleft;
        o_desc.mode      = r_f1_mode;
        o_desc.edge_pix  = r_f1_edge;
        o_desc.frame_end = r_f1_fend;
    end

endmodule

FILE: sv/idr_queue.sv
// Short descriptor queue between the front end and the arithmetic back end.
module idr_queue
    import idr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_desc               i_desc,
    input  logic                i_pop,
    output t_desc               o_desc,
    output logic                o_not_empty,
    output logic [MQ_CNT_W-1:0] o_count
);

    t_desc                r_entry [MQ_DEPTH];
    logic [MQ_PTR_W-1:0]  r_wr_ptr;
    logic [MQ_PTR_W-1:0]  r_rd_ptr;
    logic [MQ_CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + MQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + MQ_PTR_W'(1);
            end
            r_count <= r_count + MQ_CNT_W'(i_push) - MQ_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    assign o_desc      = r_entry[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;

endmodule

FILE: sv/idr_back.sv
// Back end: weighted prediction, residual and display code, with the result queue.
module idr_back
    import idr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_desc_valid,
    input  t_desc   i_desc,
    output logic    o_desc_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic                     r_b1_valid;
    logic signed [PROD_W-1:0] r_prod_a;
    logic signed [PROD_W-1:0] r_prod_b;
    logic signed [PROD_W-1:0] r_prod_c;
    logic [PIX_W-1:0]         r_b1_pixel;
    t_mode                    r_b1_mode;
    logic                     r_b1_edge;
    logic                     r_b1_fend;

    logic                     r_b2_valid;
    logic signed [SUM_W-1:0]  r_sum;
    logic [PIX_W-1:0]         r_b2_pixel;
    t_mode                    r_b2_mode;
    logic                     r_b2_edge;
    logic                     r_b2_fend;

    t_result                  r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]      r_oq_wr;
    logic [OQ_PTR_W-1:0]      r_oq_rd;
    logic [OQ_CNT_W-1:0]      r_oq_count;

    logic signed [PIX_W:0]    op_a;
    logic signed [PIX_W:0]    op_b;
    logic signed [PIX_W:0]    op_c;
    logic [OQ_CNT_W+1:0]      in_flight;
    logic                     take;
    logic                     oq_pop;
    logic signed [SUM_W-1:0]  sum_sh;
    logic signed [SUM_W-1:0]  quotient;
    logic                     round_up;
    logic signed [RES_W:0]    err;
    logic signed [RES_W:0]    k_ext;
    logic signed [RES_W:0]    diff;
    logic signed [RES_W:0]    half;
    logic signed [RES_W:0]    disp_full;
    t_result                  result;

    // Items are only taken when the result queue has room for everything in flight.
    always_comb begin
        in_flight = (OQ_CNT_W+2)'(r_oq_count) + (OQ_CNT_W+2)'(r_b1_valid)
                  + (OQ_CNT_W+2)'(r_b2_valid);
        take      = i_desc_valid && (in_flight < (OQ_CNT_W+2)'(OQ_DEPTH));
        oq_pop    = i_pop && (r_oq_count != '0);
    end

    assign o_desc_pop = take;

    // Unused terms get a zero operand; pixels are zero-extended so the products stay signed.
    always_comb begin
        op_a = $signed({1'b0, (i_desc.mode == MODE_UP) ? i_desc.up : i_desc.left});
        op_b = (i_desc.mode == MODE_LEFT_UP || i_desc.mode == MODE_PLANE)
             ? $signed({1'b0, i_desc.up}) : '0;
        op_c = (i_desc.mode == MODE_PLANE) ? $signed({1'b0, i_desc.upleft}) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prod_a   <= i_cfg.coef_a * op_a;
            r_prod_b   <= i_cfg.coef_b * op_b;
            r_prod_c   <= i_cfg.coef_c * op_c;
            r_b1_pixel <= i_desc.pixel;
            r_b1_mode  <= i_desc.mode;
            r_b1_edge  <= i_desc.edge_pix;
            r_b1_fend  <= i_desc.frame_end;
        end
        if (r_b1_valid) begin
            r_sum      <= r_prod_a + r_prod_b + r_prod_c;
            r_b2_pixel <= r_b1_pixel;
            r_b2_mode  <= r_b1_mode;
            r_b2_edge  <= r_b1_edge;
            r_b2_fend  <= r_b1_fend;
        end
        if (r_b2_valid) begin
            r_oq[r_oq_wr] <= result;
        end
    end

    // Division by 4096 truncates toward zero, so negative sums with a fraction round up.
    always_comb begin
        sum_sh    = r_sum >>> FRAC_W;
        round_up  = r_sum[SUM_W-1] && (r_sum[FRAC_W-1:0] != '0);
        quotient  = sum_sh + $signed({{(SUM_W-1){1'b0}}, round_up});
        err       = r_b2_edge ? '0
                  : $signed({{(RES_W+1-PIX_W){1'b0}}, r_b2_pixel}) - $signed(quotient[RES_W:0]);
        k_ext     = $signed({{(RES_W+1-K_W){1'b0}}, k_of_mode(r_b2_mode)});
        diff      = err - k_ext;
        half      = (diff + $signed({{RES_W{1'b0}}, diff[RES_W]})) >>> 1;
        disp_full = half + k_ext;

        result.residual     = err[RES_W-1:0];
        result.display_code = disp_full[DISP_W-1:0];
        result.edge_pixel   = r_b2_edge;
        result.frame_end    = r_b2_fend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_count <= '0;
        end else begin
            r_b1_valid <= take;
            r_b2_valid <= r_b1_valid;
            if (r_b2_valid) begin
                r_oq_wr <= r_oq_wr + OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + OQ_PTR_W'(1);
            end
            r_oq_count <= r_oq_count + OQ_CNT_W'(r_b2_valid) - OQ_CNT_W'(oq_pop);
        end
    end

    assign o_empty  = (r_oq_count == '0);
    assign o_result = r_oq[r_oq_rd];

endmodule

FILE: tb/sv/image_dpcm_residual_unit_tb.sv
// Self-checking testbench of the DPCM residual unit: directed plan, random frames, back-pressure.
`timescale 1ns / 1ps

module image_dpcm_residual_unit_tb;
    import idr_pkg::*;

    localparam int          RANDOM_ITEMS = 510;
    localparam int          WIDE_ROW     = 320;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          HOLD_AT      = 100;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          Q_ONE        = 1 << FRAC_W;
    localparam int          GAP_MAX      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef enum bit {STEP_PIXEL, STEP_WRITE} t_step_kind;

    typedef struct {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pixel;
        bit                    typed;
        t_result               want;
    } t_plan_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic [PIX_W-1:0]        i_pixel = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic signed [RES_W-1:0] o_residual;
    logic [DISP_W-1:0]       o_display_code;
    logic                    o_edge_pixel;
    logic                    o_frame_end;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    // Own copy of the block's registers and neighbourhood state.
    t_mode                    cur_mode   = MODE_LEFT;
    logic signed [COEF_W-1:0] cur_coef_a = COEF_A_RESET;
    logic signed [COEF_W-1:0] cur_coef_b = '0;
    logic signed [COEF_W-1:0] cur_coef_c = '0;
    logic [WID_W-1:0]         cur_width  = WIDTH_RESET;
    logic [HGT_W-1:0]         cur_height = HEIGHT_RESET;
    logic [PIX_W-1:0]         line_buf [MAX_WIDTH];
    logic [PIX_W-1:0]         left_px    = '0;
    logic [PIX_W-1:0]         upleft_px  = '0;
    int                       col_pos    = 0;
    logic [HGT_W-1:0]         row_pos    = '0;

    t_result   pending_residuals [$];
    t_plan_row plan [$];
    int        errors        = 0;
    int        results_seen  = 0;
    int        cycle_count   = 0;
    bit        tx_idle       = 1'b1;
    bit        rx_idle       = 1'b1;
    bit        pixels_loose  = 1'b0;

    image_dpcm_residual_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_pixel        (i_pixel),
        .empty          (empty),
        .pop            (pop),
        .o_residual     (o_residual),
        .o_display_code (o_display_code),
        .o_edge_pixel   (o_edge_pixel),
        .o_frame_end    (o_frame_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int eff_width(input logic [WID_W-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_WIDTH) return MAX_WIDTH;
        return int'(w);
    endfunction

    function automatic logic signed [31:0] weigh(input logic signed [COEF_W-1:0] c,
                                                 input logic [PIX_W-1:0] p);
        return c * $signed({1'b0, p});
    endfunction

    // Residual and display byte of one pixel; advances the neighbourhood state.
    function automatic t_result predict_residual(input logic [PIX_W-1:0] px);
        int                 w;
        int                 h;
        int                 col;
        logic [PIX_W-1:0]   up_px;
        logic signed [31:0] sum;
        logic signed [31:0] err;
        logic signed [31:0] disp;
        logic signed [31:0] k;
        bit                 on_edge;
        bit                 last_col;
        bit                 last_row;
        t_result            r;
        w = eff_width(cur_width);
        h = (cur_height == 0) ? 1 : int'(cur_height);
        col = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
        last_col = (col >= w - 1);
        last_row = (int'(row_pos) >= h - 1);
        up_px = line_buf[col];
        case (cur_mode)
            MODE_LEFT: begin
                on_edge = (col == 0);
                sum = weigh(cur_coef_a, left_px);
                k = 128;
            end
            MODE_UP: begin
                on_edge = (row_pos == 0);
                sum = weigh(cur_coef_a, up_px);
                k = 128;
            end
            MODE_LEFT_UP: begin
                on_edge = (col == 0) || (row_pos == 0);
                sum = weigh(cur_coef_a, left_px) + weigh(cur_coef_b, up_px);
                k = 256;
            end
            default: begin
                on_edge = (col == 0) || (row_pos == 0);
                sum = weigh(cur_coef_a, left_px) + weigh(cur_coef_b, up_px)
                    + weigh(cur_coef_c, upleft_px);
                k = 384;
            end
        endcase
        err = on_edge ? 0 : $signed({24'd0, px}) - sum / Q_ONE;
        disp = (err - k) / 2 + k;

        upleft_px = up_px;
        line_buf[col] = px;
        left_px = px;
        r.frame_end = 1'b0;
        if (last_col) begin
            col_pos = 0;
            if (last_row) begin
                row_pos = '0;
                r.frame_end = 1'b1;
            end else begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            col_pos = col + 1;
        end
        r.residual = err[RES_W-1:0];
        r.display_code = disp[DISP_W-1:0];
        r.edge_pixel = on_edge;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 5))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = '0;
            3: v = CFG_DATA_W'($urandom_range(3840, 4352));
            default: ;
        endcase
        return v;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        t_plan_row row;
        row.kind = STEP_WRITE;
        row.index = idx;
        row.data = data;
        row.pixel = '0;
        row.typed = 1'b0;
        row.want = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_pixel(input logic [PIX_W-1:0] px, input bit typed,
                                      input int res, input int disp, input bit on_edge,
                                      input bit fend);
        t_plan_row row;
        row.kind = STEP_PIXEL;
        row.index = '0;
        row.data = '0;
        row.pixel = px;
        row.typed = typed;
        row.want.residual = res[RES_W-1:0];
        row.want.display_code = disp[DISP_W-1:0];
        row.want.edge_pixel = on_edge;
        row.want.frame_end = fend;
        plan.push_back(row);
    endfunction

    // Called just after a falling edge; returns just after the next falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:   cur_mode = t_mode'(data[1:0]);
            CFG_COEF_A: cur_coef_a = data;
            CFG_COEF_B: cur_coef_b = data;
            CFG_COEF_C: cur_coef_c = data;
            CFG_WIDTH:  cur_width = data[WID_W-1:0];
            CFG_HEIGHT: cur_height = data[HGT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input t_result fixed_want);
        int unsigned gap;
        t_result     want;
        gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap != 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        i_pixel = px;
        do @(posedge i_clk); while (full);
        want = predict_residual(px);
        pending_residuals.push_back(typed ? fixed_want : want);
        pixels_loose = 1'b1;
        @(negedge i_clk);
    endtask

    // Registers are only touched with no pixel in flight.
    task automatic settle();
        push = 1'b0;
        if (pixels_loose) begin
            while (pending_residuals.size() != 0) @(negedge i_clk);
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            pixels_loose = 1'b0;
        end
    endtask

    task automatic random_pixel(output logic [PIX_W-1:0] px);
        case ($urandom_range(0, 7))
            0: px = 8'h00;
            1: px = 8'hFF;
            default: px = PIX_W'($urandom_range(0, 255));
        endcase
    endtask

    task automatic shuffle_regs();
        logic [CFG_DATA_W-1:0] v;
        if ($urandom_range(0, 1)) write_reg(CFG_MODE, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 1)) write_reg(CFG_COEF_A, pick_coef());
        if ($urandom_range(0, 1)) write_reg(CFG_COEF_B, pick_coef());
        if ($urandom_range(0, 1)) write_reg(CFG_COEF_C, pick_coef());
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
                0: v = 16'd0;
                1: v = 16'd1;
                default: v = CFG_DATA_W'($urandom_range(2, 12));
            endcase
            // A wider row mid-frame would read row buffer entries never written.
            if ((col_pos != 0 || row_pos != 0) && eff_width(v[WID_W-1:0]) >
                    eff_width(cur_width))
                v = {4'd0, cur_width};
            write_reg(CFG_WIDTH, v);
        end
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
                0: v = 16'd0;
                1: v = 16'hFFFF;
                default: v = CFG_DATA_W'($urandom_range(1, 5));
            endcase
            write_reg(CFG_HEIGHT, v);
        end
        if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED_LO, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED_HI, CFG_DATA_W'($urandom));
    endtask

    initial begin : feed_pixels
        logic [PIX_W-1:0] px;
        int               random_sent;
        int               n;
        t_result          none;
        none = '0;
        random_sent = 0;
        foreach (line_buf[i]) line_buf[i] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // After reset: left predictor, full weight, 640 x 480.
        add_pixel(8'h00, 1, 0, 64, 1, 0);
        add_pixel(8'hFF, 1, 255, 191, 0, 0);
        add_pixel(8'h00, 0, 0, 0, 0, 0);
        // Shrinking the row mid-frame leaves the column past its end; it closes the row.
        add_write(CFG_WIDTH, 16'd3);
        add_write(CFG_HEIGHT, 16'd2);
        add_pixel(8'h80, 0, 0, 0, 0, 0);
        add_write(CFG_MODE, {14'd0, MODE_PLANE});
        add_write(CFG_COEF_A, 16'h7FFF);
        add_write(CFG_COEF_B, 16'h8000);
        add_write(CFG_COEF_C, 16'h7FFF);
        add_pixel(8'hFF, 1, 0, 192, 1, 0);
        add_pixel(8'h00, 0, 0, 0, 0, 0);
        add_pixel(8'hFF, 0, 0, 0, 0, 0);
        add_write(CFG_MODE, {14'd0, MODE_UP});
        add_write(CFG_COEF_A, 16'h8000);
        add_pixel(8'h00, 1, 0, 64, 1, 0);
        add_pixel(8'hFF, 1, 0, 64, 1, 0);
        add_pixel(8'hAA, 1, 0, 64, 1, 0);
        add_pixel(8'h55, 0, 0, 0, 0, 0);
        add_pixel(8'hFF, 0, 0, 0, 0, 0);
        add_pixel(8'h00, 0, 0, 0, 0, 0);
        add_write(CFG_UNUSED_LO, 16'hFFFF);
        add_write(CFG_UNUSED_HI, 16'h5A5A);
        add_write(CFG_MODE, {14'd0, MODE_LEFT_UP});
        add_write(CFG_COEF_A, 16'd4096);
        add_write(CFG_COEF_B, 16'd4096);
        // Zero width and zero height both behave as one: every pixel is a whole frame.
        add_write(CFG_WIDTH, 16'd0);
        add_write(CFG_HEIGHT, 16'd0);
        add_pixel(8'hFF, 1, 0, 128, 1, 1);
        add_pixel(8'h00, 1, 0, 128, 1, 1);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_WRITE) begin
                settle();
                write_reg(plan[i].index, plan[i].data);
            end else begin
                push_pixel(plan[i].pixel, plan[i].typed, plan[i].want);
            end
        end

        // The start of a row at the widest setting, sent without gaps while the
        // receiver holds off.
        settle();
        write_reg(CFG_WIDTH, 16'hFFFF);
        write_reg(CFG_HEIGHT, 16'd1);
        write_reg(CFG_MODE, {14'd0, MODE_PLANE});
        write_reg(CFG_COEF_A, pick_coef());
        write_reg(CFG_COEF_B, pick_coef());
        write_reg(CFG_COEF_C, pick_coef());
        tx_idle = 1'b0;
        repeat (WIDE_ROW) begin
            random_pixel(px);
            push_pixel(px, 0, none);
        end

        while (random_sent < RANDOM_ITEMS) begin
            settle();
            shuffle_regs();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            n = $urandom_range(1, 40);
            repeat (n) begin
                random_pixel(px);
                push_pixel(px, 0, none);
            end
            random_sent += n;
        end

        push = 1'b0;
        while (pending_residuals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : drain_results
        int unsigned stall;
        t_result     want;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (results_seen == HOLD_AT) begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
            if (stall != 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            results_seen++;
            if (pending_residuals.size() == 0) begin
                $error("result popped with no pixel waiting for it");
                errors++;
            end else begin
                want = pending_residuals.pop_front();
                if (o_residual !== want.residual) begin
                    $error("residual: expected %0d, got %0d",
                           $signed(want.residual), $signed(o_residual));
                    errors++;
                end
                if (o_display_code !== want.display_code) begin
                    $error("display_code: expected %0d, got %0d",
                           want.display_code, o_display_code);
                    errors++;
                end
                if (o_edge_pixel !== want.edge_pixel) begin
                    $error("edge_pixel: expected %0d, got %0d",
                           want.edge_pixel, o_edge_pixel);
                    errors++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0d, got %0d",
                           want.frame_end, o_frame_end);
                    errors++;
                end
            end
        end
    end

endmodule

FILE: files.f
sv/idr_pkg.sv
sv/idr_ram.sv
sv/idr_front.sv
sv/idr_queue.sv
sv/idr_back.sv
sv/image_dpcm_residual_unit.sv
tb/sv/image_dpcm_residual_unit_tb.sv
